@@ sv/ifrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ifrc_pkg - shared types and constants of the frame transform engine
// Sizes, register and status codes, controller states and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package ifrc_pkg;

   // frame store geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   // size registers are 9 bits, so the usable size is capped by that too
   localparam int SIZE_W    = 9;
   localparam int SIZE_TOP  = (1 << SIZE_W) - 1;
   localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_LIMIT = (MAX_DIM < SIZE_TOP) ? MAX_DIM : SIZE_TOP;
   localparam int CNT_W     = $clog2(DIM_LIMIT);
   localparam int SRC_W     = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;
   localparam int AREA_W    = 2 * SIZE_W;
   localparam int CMP_W     = (AREA_W > ADDR_W + 1) ? AREA_W : ADDR_W + 1;
   localparam int PROD_W    = SRC_W + SIZE_W;

   // port field widths
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int POS_W   = 8;
   localparam int STS_W   = 2;
   localparam int REG_W   = 3;
   localparam int CSR_D_W = 9;

   // transform modes
   localparam logic [2:0] MODE_MIRROR_H = 3'd0;
   localparam logic [2:0] MODE_MIRROR_V = 3'd1;
   localparam logic [2:0] MODE_ROT_R    = 3'd2;
   localparam logic [2:0] MODE_ROT_L    = 3'd3;
   localparam logic [2:0] MODE_CROP     = 3'd4;

   // register indexes
   localparam logic [REG_W-1:0] REG_MODE        = 3'd0;
   localparam logic [REG_W-1:0] REG_IMAGE_W     = 3'd1;
   localparam logic [REG_W-1:0] REG_IMAGE_H     = 3'd2;
   localparam logic [REG_W-1:0] REG_CROP_X      = 3'd3;
   localparam logic [REG_W-1:0] REG_CROP_Y      = 3'd4;
   localparam logic [REG_W-1:0] REG_CROP_W      = 3'd5;
   localparam logic [REG_W-1:0] REG_CROP_H      = 3'd6;

   // word commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   // result status codes
   localparam logic [STS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STS_W-1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [STS_W-1:0] STATUS_NONE    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADDR,
      ST_READ,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic addr;
      logic read;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_fetch;
   } dp_sts_type;

   // size register as used: zero counts as one, large values saturate
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int unsigned max);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (32'(v) > max) begin
         r = SIZE_W'(max);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ sv/ifrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ifrc_ctrl - sequencing controller
// Accepts one word at a time and steps a fetch through execute, address,
// read and response phases of the datapath; a write only through execute.
// ----------------------------------------------------------------------------
module ifrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ifrc_pkg::dp_sts_type sts,
   output ifrc_pkg::ctl_cmd_type cmd
);

   ifrc_pkg::state_type state_ff;
   ifrc_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ifrc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      case (state_ff)
         ifrc_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ifrc_pkg::ST_EXEC;
            end
         end
         ifrc_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.is_fetch ? ifrc_pkg::ST_ADDR : ifrc_pkg::ST_IDLE;
         end
         ifrc_pkg::ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = ifrc_pkg::ST_READ;
         end
         ifrc_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = ifrc_pkg::ST_RESP;
         end
         ifrc_pkg::ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ifrc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ifrc_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   // an accepted word always goes to execute next
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ifrc_pkg::ST_EXEC))
      else $error("accepted word did not enter execute");

   // a pixel write never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ifrc_pkg::ST_EXEC && !sts.is_fetch) |=> !rsp_tvalid)
      else $error("write produced a result");

   // a result appears only after a fetch has passed through execute, address and read
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff, 3) == ifrc_pkg::ST_EXEC))
      else $error("result without preceding fetch");

   // input side and result side never open at the same time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("ready while a result is pending");
`endif

endmodule

@@ sv/ifrc_datapath.sv @@
// ----------------------------------------------------------------------------
// ifrc_datapath - frame store, counters and address arithmetic
// Holds the configuration registers, the load and emission counters,
// the pixel memory and the result register.
// ----------------------------------------------------------------------------
module ifrc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ifrc_pkg::ctl_cmd_type                 cmd,
   output ifrc_pkg::dp_sts_type                  sts,
   input  logic                                  req_command,
   input  logic [ifrc_pkg::PIX_W-1:0]            req_pixel,
   input  logic                                  csr_valid,
   input  logic [ifrc_pkg::REG_W-1:0]            csr_index,
   input  logic [ifrc_pkg::CSR_D_W-1:0]          csr_data,
   output logic [ifrc_pkg::PIX_W-1:0]            rsp_pixel,
   output logic [ifrc_pkg::POS_W-1:0]            rsp_col,
   output logic [ifrc_pkg::POS_W-1:0]            rsp_row,
   output logic                                  rsp_last,
   output logic [ifrc_pkg::STS_W-1:0]            rsp_status
);

   localparam int SIZE_W = ifrc_pkg::SIZE_W;
   localparam int CNT_W  = ifrc_pkg::CNT_W;
   localparam int SRC_W  = ifrc_pkg::SRC_W;
   localparam int ADDR_W = ifrc_pkg::ADDR_W;
   localparam int CMP_W  = ifrc_pkg::CMP_W;
   localparam int PROD_W = ifrc_pkg::PROD_W;

   // configuration
   logic [2:0]        mode_ff;
   logic [SIZE_W-1:0] img_w_ff, img_h_ff, crop_w_ff, crop_h_ff;
   logic [7:0]        crop_x_ff, crop_y_ff;

   // held word
   logic                            cmd_ff;
   logic [ifrc_pkg::PIX_W-1:0]      pix_ff;

   // load and emission state
   logic [ADDR_W-1:0] load_idx_ff, load_idx_in;
   logic              frame_ready_ff, frame_ready_in;
   logic [CNT_W-1:0]  emit_col_ff, emit_col_in;
   logic [CNT_W-1:0]  emit_row_ff, emit_row_in;
   logic              emit_done_ff, emit_done_in;

   // fetch pipeline
   logic [SRC_W-1:0]           sx_ff, sx_in, sy_ff, sy_in;
   logic [CNT_W-1:0]           col_q_ff, col_q_in, row_q_ff, row_q_in;
   logic                       last_ff, last_in;
   logic [ifrc_pkg::STS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]          addr_ff;
   logic [ifrc_pkg::PIX_W-1:0] pix_q_ff;

   // frame store
   logic [ifrc_pkg::PIX_W-1:0] store_mem [ifrc_pkg::STORE_SIZE];

   // working values
   logic [SIZE_W-1:0] w, h, ow, oh;
   logic [ADDR_W-1:0] base_idx;
   logic [CMP_W-1:0]  next_cnt, area;
   logic [SRC_W-1:0]  cx, rx, wx, hx;
   logic [SIZE_W-1:0] cz, rz;
   logic              no_pixel;
   logic [PROD_W-1:0] prod;

   assign w = ifrc_pkg::clamp_size(img_w_ff, ifrc_pkg::MAX_WIDTH);
   assign h = ifrc_pkg::clamp_size(img_h_ff, ifrc_pkg::MAX_HEIGHT);

   assign sts.is_fetch = (cmd_ff == ifrc_pkg::CMD_FETCH);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ifrc_pkg::MODE_MIRROR_H;
         img_w_ff  <= SIZE_W'(256);
         img_h_ff  <= SIZE_W'(256);
         crop_x_ff <= '0;
         crop_y_ff <= '0;
         crop_w_ff <= SIZE_W'(256);
         crop_h_ff <= SIZE_W'(256);
      end else if (csr_valid) begin
         case (csr_index)
            ifrc_pkg::REG_MODE:    mode_ff   <= csr_data[2:0];
            ifrc_pkg::REG_IMAGE_W: img_w_ff  <= csr_data[SIZE_W-1:0];
            ifrc_pkg::REG_IMAGE_H: img_h_ff  <= csr_data[SIZE_W-1:0];
            ifrc_pkg::REG_CROP_X:  crop_x_ff <= csr_data[7:0];
            ifrc_pkg::REG_CROP_Y:  crop_y_ff <= csr_data[7:0];
            ifrc_pkg::REG_CROP_W:  crop_w_ff <= csr_data[SIZE_W-1:0];
            ifrc_pkg::REG_CROP_H:  crop_h_ff <= csr_data[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // execute phase: counters for writes, source position for fetches
   always_comb begin
      load_idx_in    = load_idx_ff;
      frame_ready_in = frame_ready_ff;
      emit_col_in    = emit_col_ff;
      emit_row_in    = emit_row_ff;
      emit_done_in   = emit_done_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      col_q_in       = col_q_ff;
      row_q_in       = row_q_ff;
      last_in        = last_ff;
      status_in      = status_ff;

      // a write to a ready frame starts a new one
      base_idx = frame_ready_ff ? '0 : load_idx_ff;
      next_cnt = CMP_W'(base_idx) + CMP_W'(1);
      area     = CMP_W'({{SIZE_W{1'b0}}, w} * {{SIZE_W{1'b0}}, h});

      // output size
      case (mode_ff)
         ifrc_pkg::MODE_ROT_R, ifrc_pkg::MODE_ROT_L: begin
            ow = h;
            oh = w;
         end
         ifrc_pkg::MODE_CROP: begin
            ow = ifrc_pkg::clamp_size(crop_w_ff, ifrc_pkg::MAX_WIDTH);
            oh = ifrc_pkg::clamp_size(crop_h_ff, ifrc_pkg::MAX_HEIGHT);
         end
         default: begin
            ow = w;
            oh = h;
         end
      endcase

      cz = SIZE_W'(emit_col_ff);
      rz = SIZE_W'(emit_row_ff);
      cx = SRC_W'(emit_col_ff);
      rx = SRC_W'(emit_row_ff);
      wx = SRC_W'(w);
      hx = SRC_W'(h);
      no_pixel = !frame_ready_ff || emit_done_ff || (cz >= ow) || (rz >= oh);

      if (cmd.exec && cmd_ff == ifrc_pkg::CMD_WRITE) begin
         if (frame_ready_ff) begin
            frame_ready_in = 1'b0;
            emit_done_in   = 1'b0;
            emit_col_in    = '0;
            emit_row_in    = '0;
         end
         load_idx_in = ADDR_W'(next_cnt);
         if (next_cnt >= area) begin
            frame_ready_in = 1'b1;
            load_idx_in    = '0;
            emit_col_in    = '0;
            emit_row_in    = '0;
            emit_done_in   = 1'b0;
         end
      end else if (cmd.exec) begin
         // fetch
         if (no_pixel) begin
            if (frame_ready_ff) begin
               emit_done_in = 1'b1;
            end
            status_in = ifrc_pkg::STATUS_NONE;
            col_q_in  = '0;
            row_q_in  = '0;
            last_in   = 1'b0;
         end else begin
            case (mode_ff)
               ifrc_pkg::MODE_MIRROR_H: begin
                  sx_in = wx - SRC_W'(1) - cx;
                  sy_in = rx;
               end
               ifrc_pkg::MODE_MIRROR_V: begin
                  sx_in = cx;
                  sy_in = hx - SRC_W'(1) - rx;
               end
               ifrc_pkg::MODE_ROT_R: begin
                  sx_in = rx;
                  sy_in = hx - SRC_W'(1) - cx;
               end
               ifrc_pkg::MODE_ROT_L: begin
                  sx_in = wx - SRC_W'(1) - rx;
                  sy_in = cx;
               end
               ifrc_pkg::MODE_CROP: begin
                  sx_in = SRC_W'(crop_x_ff) + cx;
                  sy_in = SRC_W'(crop_y_ff) + rx;
               end
               default: begin
                  sx_in = cx;
                  sy_in = rx;
               end
            endcase
            status_in = ((sx_in >= wx) || (sy_in >= hx)) ? ifrc_pkg::STATUS_OUTSIDE
                                                         : ifrc_pkg::STATUS_OK;
            col_q_in  = emit_col_ff;
            row_q_in  = emit_row_ff;
            last_in   = 1'b0;
            // advance raster position
            if (cz == ow - SIZE_W'(1) && rz == oh - SIZE_W'(1)) begin
               last_in      = 1'b1;
               emit_done_in = 1'b1;
            end else if (cz == ow - SIZE_W'(1)) begin
               emit_col_in = '0;
               emit_row_in = emit_row_ff + CNT_W'(1);
            end else begin
               emit_col_in = emit_col_ff + CNT_W'(1);
            end
         end
      end
   end

   // source address: row times width plus column
   assign prod = {{SIZE_W{1'b0}}, sy_ff} * {{SRC_W{1'b0}}, w};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff    <= '0;
         frame_ready_ff <= 1'b0;
         emit_col_ff    <= '0;
         emit_row_ff    <= '0;
         emit_done_ff   <= 1'b0;
         cmd_ff         <= ifrc_pkg::CMD_WRITE;
      end else begin
         load_idx_ff    <= load_idx_in;
         frame_ready_ff <= frame_ready_in;
         emit_col_ff    <= emit_col_in;
         emit_row_ff    <= emit_row_in;
         emit_done_ff   <= emit_done_in;
         if (cmd.capture) begin
            cmd_ff <= req_command;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_ff <= req_pixel;
      end
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      col_q_ff  <= col_q_in;
      row_q_ff  <= row_q_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      if (cmd.addr) begin
         addr_ff <= ADDR_W'(prod + PROD_W'(sx_ff));
      end
   end

   // frame store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.exec && cmd_ff == ifrc_pkg::CMD_WRITE) begin
         store_mem[base_idx] <= pix_ff;
      end
      if (cmd.read) begin
         pix_q_ff <= store_mem[addr_ff];
      end
   end

   // result fields
   assign rsp_pixel  = (status_ff == ifrc_pkg::STATUS_OK) ? pix_q_ff : '0;
   assign rsp_col    = ifrc_pkg::POS_W'(col_q_ff);
   assign rsp_row    = ifrc_pkg::POS_W'(row_q_ff);
   assign rsp_last   = last_ff;
   assign rsp_status = status_ff;

endmodule

@@ sv/image_flip_rotate_crop.sv @@
// ----------------------------------------------------------------------------
// image_flip_rotate_crop - frame transform engine
// Loads an RGB frame in raster order and reads it back mirrored, rotated
// or cropped, one pixel per fetch word.
// ----------------------------------------------------------------------------
// Words are taken one at a time. A write word (tuser 0) stores one pixel,
// passes through the execute state only and gives no result. A fetch word
// (tuser 1) gives exactly one result word, held valid in the response state
// until it is taken; the next word can be taken at the earliest in the cycle
// after that result is taken. A fetch steps through execute, address
// multiply, single-port frame store read and result hold. The frame store
// has no reset; configuration writes are always taken and belong to times
// when no word is in flight.
module image_flip_rotate_crop (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_red, in_green, in_blue
   input  logic [0:0]  req_tuser,   // command
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_red, out_green, out_blue, out_col, out_row
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // status
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);

   ifrc_pkg::ctl_cmd_type cmd;
   ifrc_pkg::dp_sts_type  sts;
   logic [23:0]           pixel;
   logic [7:0]            col, row;

   assign csr_ready = 1'b1;

   ifrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // red sits in the low byte of the words, the store keeps it on top
   ifrc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_command (req_tuser[0]),
      .req_pixel   ({req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]}),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_pixel   (pixel),
      .rsp_col     (col),
      .rsp_row     (row),
      .rsp_last    (rsp_tlast),
      .rsp_status  (rsp_tuser)
   );

   assign rsp_tdata = {row, col, pixel[7:0], pixel[15:8], pixel[23:16]};

endmodule

@@ bench/frame_transform_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_transform_checker - result checker for the frame transform engine
// Watches the register, input and result channels, keeps its own copy of the
// frame store, registers and readout position, works out each fetch result
// and compares every result word field by field in order.
// ----------------------------------------------------------------------------
module frame_transform_checker
   import ifrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // in_red, in_green, in_blue
   input  logic [0:0]  req_tuser,   // command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // out_red, out_green, out_blue, out_col, out_row
   input  logic        rsp_tlast,
   input  logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data,
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
      logic              is_last;
      logic [STS_W-1:0]  status;
   } pixel_result_type;

   // shadow frame store, held as red, green, blue from the top bit down
   logic [PIX_W-1:0] frame_mem [STORE_SIZE];
   int unsigned      load_pos;
   int unsigned      emit_col;
   int unsigned      emit_row;
   bit               frame_ok;
   bit               emit_over;

   // shadow registers
   logic [2:0]       mode_q;
   logic [8:0]       img_w_q;
   logic [8:0]       img_h_q;
   logic [7:0]       crop_x_q;
   logic [7:0]       crop_y_q;
   logic [8:0]       crop_w_q;
   logic [8:0]       crop_h_q;

   pixel_result_type pixel_fifo [$];

   initial error_count = 0;

   // zero counts as one, anything above the largest size saturates
   function automatic int unsigned dim_used(input logic [8:0] v, input int unsigned top);
      if (v == '0) return 1;
      if (v > top) return top;
      return 32'(v);
   endfunction

   // load one source word; a write during readout starts a fresh frame
   function automatic void store_pixel(input logic [PIX_W-1:0] data);
      int unsigned area;
      area = dim_used(img_w_q, MAX_WIDTH) * dim_used(img_h_q, MAX_HEIGHT);
      if (frame_ok) begin
         frame_ok  = 1'b0;
         emit_over = 1'b0;
         emit_col  = 0;
         emit_row  = 0;
         load_pos  = 0;
      end
      if (load_pos < STORE_SIZE) begin
         frame_mem[ADDR_W'(load_pos)] = {data[7:0], data[15:8], data[23:16]};
      end
      load_pos++;
      if (load_pos >= area) begin
         frame_ok  = 1'b1;
         load_pos  = 0;
         emit_col  = 0;
         emit_row  = 0;
         emit_over = 1'b0;
      end
   endfunction

   // next output pixel of the transformed image, advancing the readout
   function automatic pixel_result_type next_pixel();
      int unsigned      w, h, ow, oh, c, r, sx, sy;
      logic [PIX_W-1:0] px;
      pixel_result_type res;
      w   = dim_used(img_w_q, MAX_WIDTH);
      h   = dim_used(img_h_q, MAX_HEIGHT);
      res = '0;
      px  = '0;
      case (mode_q)
         MODE_ROT_R, MODE_ROT_L: begin
            ow = h;
            oh = w;
         end
         MODE_CROP: begin
            ow = dim_used(crop_w_q, MAX_WIDTH);
            oh = dim_used(crop_h_q, MAX_HEIGHT);
         end
         default: begin
            ow = w;
            oh = h;
         end
      endcase
      c = emit_col;
      r = emit_row;

      // nothing to read: no frame, readout over, or position off the image
      if (!frame_ok || emit_over || c >= ow || r >= oh) begin
         if (frame_ok) emit_over = 1'b1;
         res.status = STATUS_NONE;
         return res;
      end

      // source position for this output position
      case (mode_q)
         MODE_MIRROR_H: begin
            sx = w - 1 - c;
            sy = r;
         end
         MODE_MIRROR_V: begin
            sx = c;
            sy = h - 1 - r;
         end
         MODE_ROT_R: begin
            sx = r;
            sy = h - 1 - c;
         end
         MODE_ROT_L: begin
            sx = w - 1 - r;
            sy = c;
         end
         MODE_CROP: begin
            sx = crop_x_q + c;
            sy = crop_y_q + r;
         end
         default: begin
            sx = c;
            sy = r;
         end
      endcase

      if (sx >= w || sy >= h) begin
         res.status = STATUS_OUTSIDE;
      end else begin
         px         = frame_mem[ADDR_W'(sy * w + sx)];
         res.status = STATUS_OK;
      end

      // raster advance
      if (c == ow - 1 && r == oh - 1) begin
         res.is_last = 1'b1;
         emit_over   = 1'b1;
      end else if (c == ow - 1) begin
         emit_col = 0;
         emit_row = r + 1;
      end else begin
         emit_col = c + 1;
      end

      res.red   = px[23:16];
      res.green = px[15:8];
      res.blue  = px[7:0];
      res.col   = c[POS_W-1:0];
      res.row   = r[POS_W-1:0];
      return res;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   // channel watch, results handled before new fetches are queued
   always @(posedge clock) begin : watch
      pixel_result_type want;
      if (reset) begin
         load_pos  = 0;
         emit_col  = 0;
         emit_row  = 0;
         frame_ok  = 1'b0;
         emit_over = 1'b0;
         mode_q    = MODE_MIRROR_H;
         img_w_q   = 9'd256;
         img_h_q   = 9'd256;
         crop_x_q  = 8'd0;
         crop_y_q  = 8'd0;
         crop_w_q  = 9'd256;
         crop_h_q  = 9'd256;
         pixel_fifo.delete();
      end else begin
         // compare a result word with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_fifo.size() == 0) begin
               $error("result word with no fetch outstanding");
               error_count++;
            end else begin
               want = pixel_fifo.pop_front();
               check_field("out_red",    32'(want.red),     32'(rsp_tdata[7:0]));
               check_field("out_green",  32'(want.green),   32'(rsp_tdata[15:8]));
               check_field("out_blue",   32'(want.blue),    32'(rsp_tdata[23:16]));
               check_field("out_col",    32'(want.col),     32'(rsp_tdata[31:24]));
               check_field("out_row",    32'(want.row),     32'(rsp_tdata[39:32]));
               check_field("last_pixel", 32'(want.is_last), 32'(rsp_tlast));
               check_field("status",     32'(want.status),  32'(rsp_tuser));
            end
         end

         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE:    mode_q   = csr_data[2:0];
               REG_IMAGE_W: img_w_q  = csr_data;
               REG_IMAGE_H: img_h_q  = csr_data;
               REG_CROP_X:  crop_x_q = csr_data[7:0];
               REG_CROP_Y:  crop_y_q = csr_data[7:0];
               REG_CROP_W:  crop_w_q = csr_data;
               REG_CROP_H:  crop_h_q = csr_data;
               default: ;
            endcase
         end

         // input words
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == CMD_WRITE) begin
               store_pixel(req_tdata);
            end else begin
               pixel_fifo.push_back(next_pixel());
            end
         end
      end
      pending_count = pixel_fifo.size();
   end

endmodule

@@ bench/image_flip_rotate_crop_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_flip_rotate_crop_tb - testbench of the frame transform engine
// Loads frames of many sizes, reads them back in every mode with random
// gaps and back pressure, changes registers between and during readouts,
// and leaves all checking to the checker beside the block.
// ----------------------------------------------------------------------------
module image_flip_rotate_crop_tb;
   import ifrc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int WORD_TARGET   = 1070;
   localparam int SETTLE_CYCLES = 6;
   localparam int FETCH_CAP     = 64;
   localparam logic [REG_W-1:0] REG_SPARE = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [8:0]  csr_data;

   int          error_count;
   int          pending_count;
   int          cycle_count = 0;
   int          words_sent  = 0;

   // idling limits, redrawn per phase
   int          req_gap_max;
   int          rsp_gap_max;
   int          rsp_hold = 0;
   logic        rsp_took = 1'b0;

   // what the stimulus knows about the block, as used sizes
   int          img_w;
   int          img_h;
   int          crop_w_eff;
   int          crop_h_eff;
   logic [2:0]  cur_mode;
   int          load_pos;
   bit          frame_full;
   bit          must_load;

   always #5 clock = ~clock;

   image_flip_rotate_crop i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   frame_transform_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result back pressure: a fresh stall after every taken result word
   always @(posedge clock) begin
      rsp_took <= rsp_tvalid && rsp_tready;
   end

   always @(negedge clock) begin
      if (rsp_took) rsp_hold = $urandom_range(0, rsp_gap_max);
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int dim_of(input logic [8:0] v);
      if (v == '0) return 1;
      if (v > 256) return 256;
      return int'(v);
   endfunction

   function automatic int out_pixels();
      if (cur_mode == MODE_CROP) return crop_w_eff * crop_h_eff;
      return img_w * img_h;
   endfunction

   function automatic int pick_gap_max();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 4;
         default: return 16;
      endcase
   endfunction

   // stop sending and wait until every result is in and the block is idle
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_reg(input logic [REG_W-1:0] idx, input logic [8:0] data);
      settle();
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_MODE:    cur_mode = data[2:0];
         REG_IMAGE_W: begin
            img_w     = dim_of(data);
            must_load = 1'b1;
         end
         REG_IMAGE_H: begin
            img_h     = dim_of(data);
            must_load = 1'b1;
         end
         REG_CROP_W:  crop_w_eff = dim_of(data);
         REG_CROP_H:  crop_h_eff = dim_of(data);
         default: ;
      endcase
   endtask

   // one input word after a random gap; valid stays up after the handshake
   task automatic send_word(input logic cmd, input logic [23:0] data);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (cmd == CMD_WRITE) begin
         if (frame_full) begin
            frame_full = 1'b0;
            load_pos   = 0;
         end
         load_pos++;
         if (load_pos >= img_w * img_h) begin
            frame_full = 1'b1;
            load_pos   = 0;
         end
      end
   endtask

   task automatic fetch_run(input int n);
      repeat (n) send_word(CMD_FETCH, 24'($urandom()));
   endtask

   task automatic set_random_mode();
      logic [2:0] m;
      m = ($urandom_range(0, 3) == 0) ? MODE_CROP : 3'($urandom_range(0, 7));
      set_reg(REG_MODE, {6'($urandom_range(0, 63)), m});
   endtask

   task automatic set_random_crop();
      int cw, ch;
      cw = $urandom_range(1, 10);
      ch = $urandom_range(1, 10);
      set_reg(REG_CROP_X, {1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 1) ? $urandom_range(0, img_w)
                                                   : $urandom_range(0, 255))});
      set_reg(REG_CROP_Y, {1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 1) ? $urandom_range(0, img_h)
                                                   : $urandom_range(0, 255))});
      set_reg(REG_CROP_W, (cw == 1 && $urandom_range(0, 1)) ? 9'd0 : 9'(cw));
      set_reg(REG_CROP_H, (ch == 1 && $urandom_range(0, 1)) ? 9'd0 : 9'(ch));
   endtask

   // one phase: registers, a frame load (maybe broken), then a readout
   task automatic run_phase(input int ph);
      int wv, hv, n, k, cap;
      req_gap_max = pick_gap_max();
      rsp_gap_max = pick_gap_max();

      case (ph)
         // widest frame, one row high
         1: begin
            set_reg(REG_IMAGE_W, 9'd511);
            set_reg(REG_IMAGE_H, 9'd0);
            set_reg(REG_MODE, {6'h2A, MODE_MIRROR_H});
         end
         // tallest frame, one column wide
         3: begin
            set_reg(REG_IMAGE_W, 9'd1);
            set_reg(REG_IMAGE_H, 9'd256);
            set_reg(REG_MODE, {6'h15, MODE_ROT_L});
         end
         // tall crop window running off the bottom
         4: begin
            set_reg(REG_MODE, 9'(MODE_CROP));
            set_reg(REG_CROP_X, 9'd0);
            set_reg(REG_CROP_Y, 9'd200);
            set_reg(REG_CROP_W, 9'd0);
            set_reg(REG_CROP_H, 9'd256);
         end
         // crop window at the far corner, fully outside
         5: begin
            set_reg(REG_CROP_X, 9'h1FF);
            set_reg(REG_CROP_Y, 9'd255);
            set_reg(REG_CROP_W, 9'd511);
            set_reg(REG_CROP_H, 9'd0);
         end
         default: begin
            if (ph == 0 || $urandom_range(0, 9) < 4) begin
               wv = $urandom_range(1, 8);
               hv = $urandom_range(1, 8);
               set_reg(REG_IMAGE_W, (wv == 1 && $urandom_range(0, 1)) ? 9'd0 : 9'(wv));
               set_reg(REG_IMAGE_H, (hv == 1 && $urandom_range(0, 1)) ? 9'd0 : 9'(hv));
            end
            set_random_mode();
            if (cur_mode == MODE_CROP) set_random_crop();
            if ($urandom_range(0, 9) == 0) set_reg(REG_SPARE, 9'($urandom()));
         end
      endcase

      // frame load, sometimes broken off by an early fetch
      if (must_load || !frame_full || $urandom_range(0, 3) == 0) begin
         if (img_w * img_h > 1 && $urandom_range(0, 2) == 0) begin
            k = $urandom_range(1, img_w * img_h - 1);
            repeat (k) send_word(CMD_WRITE, 24'($urandom()));
            if (frame_full || !must_load) send_word(CMD_FETCH, 24'($urandom()));
         end
         do send_word(CMD_WRITE, 24'($urandom())); while (!frame_full);
         must_load = 1'b0;
      end

      // readout, sometimes with a register change part way through
      n   = out_pixels();
      cap = (ph == 1) ? n + 1 : FETCH_CAP;
      if (ph > 5 && n > 2 && $urandom_range(0, 4) == 0) begin
         k = $urandom_range(1, n - 1);
         fetch_run((k > cap) ? cap : k);
         set_random_mode();
         if (cur_mode == MODE_CROP && $urandom_range(0, 1)) set_random_crop();
         n = out_pixels() + 1;
         fetch_run((n > cap) ? cap : n);
      end else begin
         n = n + $urandom_range(0, 2);
         fetch_run((n > cap) ? cap : n);
      end
   endtask

   initial begin
      int ph;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_WRITE;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = REG_MODE;
      csr_data    = '0;
      req_gap_max = 16;
      rsp_gap_max = 16;
      img_w       = 256;
      img_h       = 256;
      crop_w_eff  = 256;
      crop_h_eff  = 256;
      cur_mode    = MODE_MIRROR_H;
      load_pos    = 0;
      frame_full  = 1'b0;
      must_load   = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fetch before any frame
      send_word(CMD_FETCH, 24'hFFFFFF);

      // zero width counts as one, rotated readout of a 1x3 frame
      set_reg(REG_IMAGE_W, 9'd0);
      set_reg(REG_IMAGE_H, 9'd3);
      set_reg(REG_MODE, {6'h3F, MODE_ROT_R});
      send_word(CMD_WRITE, 24'h000000);
      send_word(CMD_WRITE, 24'hFFFFFF);
      send_word(CMD_WRITE, 24'h5AA55A);
      fetch_run(4);

      // write while a frame is ready restarts the load
      send_word(CMD_WRITE, 24'hA55AA5);
      send_word(CMD_FETCH, 24'h000000);
      send_word(CMD_WRITE, 24'h00FF00);
      send_word(CMD_WRITE, 24'hFF00FF);

      // crop window partly outside the frame
      set_reg(REG_MODE, 9'(MODE_CROP));
      set_reg(REG_CROP_X, 9'd0);
      set_reg(REG_CROP_Y, 9'h101);
      set_reg(REG_CROP_W, 9'd2);
      set_reg(REG_CROP_H, 9'd3);
      fetch_run(7);

      // random phases
      ph = 0;
      while (words_sent < WORD_TARGET) begin
         run_phase(ph);
         ph++;
      end

      settle();
      if (error_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
